@@ hw/rtl/upx2_pkg.sv @@
// ----------------------------------------------------------------------------
// upx2_pkg
// Shared constants, widths and helpers for the 2x image upscaler.
// ----------------------------------------------------------------------------
package upx2_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int ColW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RowW   = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int DimW   = 11;
  localparam int PixW   = 8;
  localparam int CoordW = 11;

  localparam int OutFieldW = 2 * CoordW + PixW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = DimW;

  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 1'b1;

  localparam logic [DimW-1:0] DimReset = DimW'(64);

  // floor((a + b) / 2)
  function automatic logic [PixW-1:0] avg2(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b);
    logic [PixW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[PixW:1];
  endfunction

  // zero acts as one, large values saturate
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input int maxv);
    logic [DimW-1:0] res;
    res = v;
    if (v == '0) res = DimW'(1);
    else if (32'(v) > maxv) res = DimW'(maxv);
    return res;
  endfunction

endpackage

@@ hw/rtl/image_upscale_2x_interpolate_unit.sv @@
// A pixel passes the read stage, the result generator and then the result
// register. Throughput: one result per cycle while out_tready is high; a pixel
// causes 1 to 9 results (usually 4), all through the single result register.
// A new pixel is taken whenever the read stage is empty or loads the result generator.
// Reset: counters and left-neighbour pixel registers clear, both sizes return to 64; the
// row memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// image_upscale_2x_interpolate_unit
// Streaming 2x upscaler: raster source pixels in, tagged doubled-image
// pixels out, previous source row kept in a single-port line memory.
// ----------------------------------------------------------------------------
module image_upscale_2x_interpolate_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [upx2_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [upx2_pkg::CfgDataW-1:0]     cfg_data,
  // source pixels
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [upx2_pkg::PixW-1:0]         in_tdata,   // [7:0] pixel_in
  // doubled image
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [upx2_pkg::OutDataW-1:0]     out_tdata,  // out_row, out_col, pixel_out, zeros
  output logic                              out_tlast,  // run_last
  output logic                              out_tuser   // [0] frame_last
);

  localparam int PixW   = upx2_pkg::PixW;
  localparam int ColW   = upx2_pkg::ColW;
  localparam int RowW   = upx2_pkg::RowW;
  localparam int DimW   = upx2_pkg::DimW;
  localparam int CoordW = upx2_pkg::CoordW;

  // configuration and frame position
  logic [DimW-1:0] src_width_r, src_height_r;
  logic [DimW-1:0] w_eff, h_eff;
  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic            c_last, r_last, in_acc;

  // line memory
  logic [PixW-1:0] row_mem [upx2_pkg::MaxWidth];
  logic [PixW-1:0] rd_q;
  logic [PixW-1:0] cur_left_r, prev_left_r;

  // read stage
  logic            a_valid_r;
  logic [PixW-1:0] a_pix_r, a_left_r;
  logic [ColW-1:0] a_col_r;
  logic [RowW-1:0] a_row_r;
  logic            a_clast_r, a_rlast_r;

  // result generator
  logic              b_valid_r;
  logic [PixW-1:0]   b_cur_r [3];
  logic [PixW-1:0]   b_top_r [3];
  logic [CoordW-1:0] b_col_r;
  logic [RowW-1:0]   b_row_r;
  logic [1:0]        b_ncol_r, b_rr_r, b_rend_r, b_k_r;
  logic              b_flast_r;
  logic              b_last, b_adv, b_load;
  logic [PixW-1:0]   b_pix;
  logic [CoordW-1:0] b_ocol, b_orow;

  // result register
  logic                          out_valid_r, out_last_r, out_user_r;
  logic [upx2_pkg::OutDataW-1:0] out_data_r;

  assign w_eff = upx2_pkg::clamp_dim(src_width_r, upx2_pkg::MaxWidth);
  assign h_eff = upx2_pkg::clamp_dim(src_height_r, upx2_pkg::MaxHeight);

  assign c_last = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign r_last = (32'(row_r) + 32'd1) >= 32'(h_eff);

  assign b_last = (b_rr_r == b_rend_r) && (b_k_r == b_ncol_r - 2'd1);
  assign b_adv  = b_valid_r && (!out_valid_r || out_tready);
  assign b_load = a_valid_r && (!b_valid_r || (b_adv && b_last));

  assign in_tready = !a_valid_r || b_load;
  assign in_acc    = in_tvalid && in_tready;

  // next source position
  always_comb begin
    col_nxt = col_r + ColW'(1);
    row_nxt = row_r;
    if (c_last) begin
      col_nxt = '0;
      row_nxt = r_last ? '0 : row_r + RowW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= upx2_pkg::DimReset;
      src_height_r <= upx2_pkg::DimReset;
      col_r        <= '0;
      row_r        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        upx2_pkg::CfgSrcWidth:  src_width_r  <= cfg_data;
        upx2_pkg::CfgSrcHeight: src_height_r <= cfg_data;
        default: ;
      endcase
      // restart the frame
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // read old entry, write new pixel in the same cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q           <= row_mem[col_r];
      row_mem[col_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      cur_left_r  <= '0;
      prev_left_r <= '0;
    end else begin
      if (in_acc) begin
        a_valid_r  <= 1'b1;
        cur_left_r <= in_tdata;
      end else if (b_load) begin
        a_valid_r <= 1'b0;
      end
      if (b_load) prev_left_r <= rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r   <= in_tdata;
      a_left_r  <= cur_left_r;
      a_col_r   <= col_r;
      a_row_r   <= row_r;
      a_clast_r <= c_last;
      a_rlast_r <= r_last;
    end
  end

  // result generator control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_rr_r    <= '0;
      b_k_r     <= '0;
    end else if (b_load) begin
      b_valid_r <= 1'b1;
      b_k_r     <= '0;
      b_rr_r    <= (a_row_r != '0) ? 2'd0 : 2'd1;
    end else if (b_adv) begin
      if (b_last) begin
        b_valid_r <= 1'b0;
      end else if (b_k_r == b_ncol_r - 2'd1) begin
        b_k_r  <= '0;
        b_rr_r <= b_rr_r + 2'd1;
      end else begin
        b_k_r <= b_k_r + 2'd1;
      end
    end
  end

  // column values of the loaded pixel
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_row_r   <= a_row_r;
      b_rend_r  <= a_rlast_r ? 2'd2 : 2'd1;
      b_flast_r <= a_clast_r && a_rlast_r;
      b_cur_r[1] <= a_pix_r;
      b_cur_r[2] <= a_pix_r;
      b_top_r[1] <= rd_q;
      b_top_r[2] <= rd_q;
      if (a_col_r != '0) begin
        b_cur_r[0] <= upx2_pkg::avg2(a_left_r, a_pix_r);
        b_top_r[0] <= upx2_pkg::avg2(prev_left_r, rd_q);
        b_col_r    <= CoordW'(32'(a_col_r) * 32'd2 - 32'd1);
        b_ncol_r   <= a_clast_r ? 2'd3 : 2'd2;
      end else begin
        b_cur_r[0] <= a_pix_r;
        b_top_r[0] <= rd_q;
        b_col_r    <= '0;
        b_ncol_r   <= a_clast_r ? 2'd2 : 2'd1;
      end
    end
  end

  assign b_pix  = (b_rr_r == 2'd0) ? upx2_pkg::avg2(b_top_r[b_k_r], b_cur_r[b_k_r])
                                   : b_cur_r[b_k_r];
  assign b_ocol = b_col_r + CoordW'(b_k_r);
  assign b_orow = CoordW'(32'(b_row_r) * 32'd2 + 32'(b_rr_r) - 32'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data_r <= upx2_pkg::OutDataW'({b_pix, b_ocol, b_orow});
      out_last_r <= b_last;
      out_user_r <= b_last && b_flast_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without run end");

  a_gen_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_rr_r <= b_rend_r) && (b_k_r < b_ncol_r))
    else $error("result generator index out of range");

  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside the results of one pixel");

  a_read_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_load |=> a_valid_r && $stable(a_col_r))
    else $error("read stage lost a pixel");
`endif

endmodule
